### rtl/wea_pkg.sv
// Shared types, constants and the log2 table generator for the weighted entropy accumulator.
// No dependencies.
package wea_pkg;

    localparam int unsigned WEA_FRAC_BITS     = 16;
    localparam int unsigned WEA_LOG_ADDR_BITS = 8;

    localparam logic [32:0] WEA_PEND_MAX = {33{1'b1}};
    localparam logic [47:0] WEA_SUM_MAX  = {48{1'b1}};
    localparam logic [21:0] WEA_ENT_MAX  = {22{1'b1}};

    typedef struct packed {
        logic [30:0] entry_key;
        logic [31:0] entry_weight;
        logic        last_entry;
    } wea_in_t;

    typedef struct packed {
        logic [21:0] entropy_bits;
        logic [47:0] total_weight;
        logic        overflow;
    } wea_out_t;

    // log2(1 + i/2^a) in Q2.30 by bit-serial squaring of a Q1.31 mantissa
    function automatic logic [31:0] wea_rom_value(input int unsigned i, input int unsigned a);
        logic [63:0] m;
        logic [31:0] r;
        r = '0;
        if (i >= (32'd1 << a)) begin
            return 32'h4000_0000;
        end
        m = 64'h8000_0000 + (64'(i) << (31 - a));
        for (int j = 29; j >= 0; j--) begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000) begin
                r[j] = 1'b1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

endpackage

### rtl/wea_log2_unit.sv
// Iterative fixed-point log2: six-step normalize, table lookup, interpolation multiply.
// Depends on wea_pkg.
module wea_log2_unit #(
    parameter int unsigned FRAC_BITS     = wea_pkg::WEA_FRAC_BITS,
    parameter int unsigned LOG_ADDR_BITS = wea_pkg::WEA_LOG_ADDR_BITS,
    parameter int unsigned LOGW          = FRAC_BITS + 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [47:0]            x,
    output logic                   done,
    output logic signed [LOGW-1:0] result
);
    import wea_pkg::*;

    localparam int unsigned ROM_SIZE = (1 << LOG_ADDR_BITS) + 1;
    localparam int unsigned RW       = 32 - LOG_ADDR_BITS;

    typedef enum logic [1:0] {L_IDLE, L_NORM, L_INTERP, L_RES} lstate_t;

    lstate_t              state_reg;
    logic [2:0]           step_reg;
    logic [47:0]          v_reg;
    logic [5:0]           k_reg;
    logic [31:0]          base_reg;
    logic [31+RW:0]       prod_reg;
    logic                 done_reg;
    logic signed [LOGW-1:0] result_reg;

    logic [31:0] rom [ROM_SIZE];
    for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
        assign rom[g] = wea_rom_value(g, LOG_ADDR_BITS);
    end

    logic [5:0]                 sh;
    logic [31:0]                frac;
    logic [LOG_ADDR_BITS-1:0]   idx;
    logic [LOG_ADDR_BITS:0]     idx1;
    logic [RW-1:0]              rem;
    logic [31:0]                diff;
    logic [31:0]                y;
    logic signed [LOGW-1:0]     kint;

    always_comb begin
        sh   = 6'd32 >> step_reg;
        frac = v_reg[46:15];
        idx  = frac[31 -: LOG_ADDR_BITS];
        idx1 = {1'b0, idx} + 1'b1;
        rem  = frac[RW-1:0];
        diff = rom[idx1] - rom[idx];
        y    = base_reg + prod_reg[31+RW:RW];
        kint = $signed({{(LOGW-6){1'b0}}, k_reg}) - $signed(LOGW'(FRAC_BITS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end else begin
            done_reg <= (state_reg == L_RES);
            case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        v_reg     <= x;
                        k_reg     <= 6'd47;
                        step_reg  <= '0;
                        state_reg <= L_NORM;
                    end
                end
                L_NORM: begin
                    // shift out leading zeros, halving the window each step
                    if ((v_reg >> (6'd48 - sh)) == 48'd0) begin
                        v_reg <= v_reg << sh;
                        k_reg <= k_reg - sh;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd5) begin
                        state_reg <= L_INTERP;
                    end
                end
                L_INTERP: begin
                    base_reg  <= rom[idx];
                    prod_reg  <= diff * rem;
                    state_reg <= L_RES;
                end
                L_RES: begin
                    result_reg <= (kint <<< FRAC_BITS)
                                + $signed({{(LOGW-FRAC_BITS-2){1'b0}}, y[31:30-FRAC_BITS]});
                    state_reg  <= L_IDLE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/wea_divider.sv
// Restoring divider, one quotient bit per cycle: 64-bit dividend by 48-bit divisor.
// Depends on wea_pkg.
module wea_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [47:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    import wea_pkg::*;

    logic        busy_reg;
    logic [6:0]  cnt_reg;
    logic [48:0] rem_reg;
    logic [63:0] quo_reg;
    logic [47:0] dsr_reg;
    logic        done_reg;
    logic [49:0] trial;
    logic [49:0] diffv;

    always_comb begin
        trial = {rem_reg, quo_reg[63]};
        diffv = trial - {2'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 7'd63);
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                if (!diffv[49]) begin
                    rem_reg <= diffv[48:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rem_reg <= trial[48:0];
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/weighted_entropy_accumulator.sv
// Weighted entropy accumulator top level: sequencer, accumulators and result register.
// Depends on wea_pkg, wea_log2_unit and wea_divider.
// Accepts one weight request at a time. A request that merges into the pending key is
// absorbed in the idle state; a request that closes a key runs the shared log2 unit before
// the next request is taken (the log2 pass is skipped when the closed key has zero weight).
// A last request adds a closing pass with the divider before its result is raised; one that
// opens a new key first closes that key too. The log2 unit sets the per-key cost
// and the divider the per-distribution cost. The result register lets a finished result
// wait while the next request is taken.
module weighted_entropy_accumulator #(
    parameter int unsigned FRAC_BITS           = wea_pkg::WEA_FRAC_BITS,
    parameter int unsigned LOG_TABLE_ADDR_BITS = wea_pkg::WEA_LOG_ADDR_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wea_pkg::wea_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output wea_pkg::wea_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import wea_pkg::*;

    localparam int unsigned LOGW = FRAC_BITS + 8;
    localparam int unsigned PW   = 34 + LOGW;
    localparam int unsigned SW   = ((PW > 64) ? PW : 64) + 1;
    localparam int unsigned EW   = 66;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FLUSH, ST_LOG_WAIT, ST_ACC, ST_NEXT,
        ST_FIN, ST_FIN_WAIT, ST_COMBINE, ST_OUT
    } state_t;

    state_t              state_reg;
    logic                merge_reg;
    logic                phase_fin_reg;
    wea_in_t             item_reg;
    logic [30:0]         pkey_reg;
    logic [32:0]         pw_reg;
    logic                pv_reg;
    logic signed [63:0]  acc_reg;
    logic [47:0]         wsum_reg;
    logic                sat_reg;
    logic signed [PW-1:0] term_reg;
    logic                m_valid_reg;
    wea_out_t            m_data_reg;
    wea_out_t            res_reg;
    logic                log_start;
    logic                div_start;

    logic                   log_done;
    logic signed [LOGW-1:0] log_res;
    logic                   div_done;
    logic [63:0]            quo;

    wea_log2_unit #(
        .FRAC_BITS    (FRAC_BITS),
        .LOG_ADDR_BITS(LOG_TABLE_ADDR_BITS),
        .LOGW         (LOGW)
    ) u_log (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (log_start),
        .x      ((state_reg == ST_FLUSH) ? {15'd0, pw_reg} : wsum_reg),
        .done   (log_done),
        .result (log_res)
    );

    logic [63:0] mag;
    assign mag = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;

    wea_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(mag),
        .divisor (wsum_reg),
        .done    (div_done),
        .quotient(quo)
    );

    logic               merge_hit;
    logic [33:0]        merged;
    logic signed [SW-1:0] acc_sum;
    logic signed [SW-1:0] acc_max;
    logic signed [SW-1:0] acc_min;
    logic [48:0]        wsum_sum;
    logic signed [EW-1:0] ent;
    logic               acc_hi;
    logic               acc_lo;
    logic               wsum_ovf;
    logic               out_fire;

    always_comb begin
        merge_hit = merge_reg && pv_reg && (s_data.entry_key == pkey_reg);
        merged    = {1'b0, pw_reg} + {2'b0, s_data.entry_weight};
        acc_sum   = SW'(acc_reg) + SW'(term_reg);
        acc_max   = $signed({{(SW-63){1'b0}}, {63{1'b1}}});
        acc_min   = $signed({{(SW-63){1'b1}}, {63{1'b0}}});
        acc_hi    = (acc_sum > acc_max);
        acc_lo    = (acc_sum < acc_min);
        wsum_sum  = {1'b0, wsum_reg} + {16'd0, pw_reg};
        wsum_ovf  = (wsum_sum > {1'b0, WEA_SUM_MAX});
        ent       = acc_reg[63] ? (EW'(log_res) + $signed({2'b0, quo}))
                                : (EW'(log_res) - $signed({2'b0, quo}));
        log_start = ((state_reg == ST_FLUSH) && pv_reg && (pw_reg != 33'd0))
                 || ((state_reg == ST_FIN) && (wsum_reg != 48'd0));
        div_start = (state_reg == ST_FIN) && (wsum_reg != 48'd0);
        out_fire  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            merge_reg     <= 1'b1;
            phase_fin_reg <= 1'b0;
            pkey_reg      <= '0;
            pw_reg        <= '0;
            pv_reg        <= 1'b0;
            acc_reg       <= '0;
            wsum_reg      <= '0;
            sat_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                merge_reg <= cfg_data;
            end
            if (out_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_data;
                        if (merge_hit) begin
                            if (merged > {1'b0, WEA_PEND_MAX}) begin
                                pw_reg  <= WEA_PEND_MAX;
                                sat_reg <= 1'b1;
                            end else begin
                                pw_reg <= merged[32:0];
                            end
                            if (s_data.last_entry) begin
                                phase_fin_reg <= 1'b1;
                                state_reg     <= ST_FLUSH;
                            end
                        end else begin
                            phase_fin_reg <= 1'b0;
                            state_reg     <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (log_start) begin
                        state_reg <= ST_LOG_WAIT;
                    end else begin
                        pv_reg    <= 1'b0;
                        state_reg <= ST_NEXT;
                    end
                end
                ST_LOG_WAIT: begin
                    if (log_done) begin
                        term_reg  <= $signed({1'b0, pw_reg}) * log_res;
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (acc_hi) begin
                        acc_reg <= acc_max[63:0];
                    end else if (acc_lo) begin
                        acc_reg <= acc_min[63:0];
                    end else begin
                        acc_reg <= acc_sum[63:0];
                    end
                    if (wsum_ovf) begin
                        wsum_reg <= WEA_SUM_MAX;
                    end else begin
                        wsum_reg <= wsum_sum[47:0];
                    end
                    if (acc_hi || acc_lo || wsum_ovf) begin
                        sat_reg <= 1'b1;
                    end
                    pv_reg    <= 1'b0;
                    state_reg <= ST_NEXT;
                end
                ST_NEXT: begin
                    if (phase_fin_reg) begin
                        state_reg <= ST_FIN;
                    end else begin
                        pkey_reg <= item_reg.entry_key;
                        pw_reg   <= {1'b0, item_reg.entry_weight};
                        pv_reg   <= 1'b1;
                        if (item_reg.last_entry) begin
                            phase_fin_reg <= 1'b1;
                            state_reg     <= ST_FLUSH;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_FIN: begin
                    if (wsum_reg == 48'd0) begin
                        res_reg.entropy_bits <= '0;
                        res_reg.total_weight <= '0;
                        res_reg.overflow     <= sat_reg;
                        state_reg            <= ST_OUT;
                    end else begin
                        state_reg <= ST_FIN_WAIT;
                    end
                end
                ST_FIN_WAIT: begin
                    // divider always finishes well after the log2 unit
                    if (div_done) begin
                        state_reg <= ST_COMBINE;
                    end
                end
                ST_COMBINE: begin
                    res_reg.total_weight <= wsum_reg;
                    if (ent < 0) begin
                        res_reg.entropy_bits <= '0;
                        res_reg.overflow     <= sat_reg;
                    end else if (ent > $signed({{(EW-22){1'b0}}, WEA_ENT_MAX})) begin
                        res_reg.entropy_bits <= WEA_ENT_MAX;
                        res_reg.overflow     <= 1'b1;
                    end else begin
                        res_reg.entropy_bits <= ent[21:0];
                        res_reg.overflow     <= sat_reg;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // hold until the result register is free, then clear for the next set
                    if (out_fire) begin
                        m_data_reg    <= res_reg;
                        pkey_reg      <= '0;
                        pw_reg        <= '0;
                        pv_reg        <= 1'b0;
                        acc_reg       <= '0;
                        wsum_reg      <= '0;
                        sat_reg       <= 1'b0;
                        phase_fin_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    a_zero_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.total_weight == 48'd0) |-> (m_data.entropy_bits == 22'd0))
        else $error("nonzero entropy with zero total");

    a_rise_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_FIN_WAIT))
        else $error("divider finished outside final wait");

endmodule
